FILE: sv/apgas_pkg.sv
package apgas_pkg;

	// fixed field widths
	localparam int IDX_BITS   = 10;
	localparam int VAL_BITS   = 32;
	localparam int TOTAL_BITS = 42;
	localparam int CNT_BITS   = 11;

	// entry tag width for the lazy set-all
	localparam int EPOCH_BITS = 8;

	// reset value of the entry count register
	localparam logic [CNT_BITS-1:0] CNT_RESET = 11'd1024;

	// action codes
	localparam logic ACT_POINT = 1'b0;
	localparam logic ACT_ALL   = 1'b1;

	typedef struct packed {
		logic                action;
		logic [IDX_BITS-1:0] index;
		logic [VAL_BITS-1:0] value;
	} item_t;

	typedef struct packed {
		logic [TOTAL_BITS-1:0] total;
		logic                  bad_index;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mem_rd;
		logic point_upd;
		logic set_all;
		logic bad_emit;
		logic clr_en;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_set_all;
		logic bad;
		logic epoch_wrap;
		logic clr_last;
	} status_t;

endpackage

FILE: sv/apgas_ctrl.sv
module apgas_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  apgas_pkg::status_t status,
	output apgas_pkg::cmd_t    cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;
	localparam logic [1:0] S_RMW   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// state register, clearing pass runs first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (status.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (status.is_set_all) begin
					cmd.set_all = 1'b1;
					state_d     = status.epoch_wrap ? S_CLEAR : S_IDLE;
				end else if (status.bad) begin
					cmd.bad_emit = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.mem_rd = 1'b1;
					state_d    = S_RMW;
				end
			end
			S_RMW: begin
				cmd.point_upd = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/apgas_dp.sv
module apgas_dp #(
	parameter int MAX_ENTRIES = 1024,
	parameter int VALUE_BITS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  apgas_pkg::item_t                    item,
	input  logic                                cfg_valid,
	input  logic [apgas_pkg::CNT_BITS-1:0]      cfg_data,
	input  apgas_pkg::cmd_t                     cmd,
	output apgas_pkg::status_t                  status,
	output apgas_pkg::result_t                  result,
	output logic                                done
);

	// stored width and reachable depth
	localparam int SW    = (VALUE_BITS < apgas_pkg::VAL_BITS) ? VALUE_BITS : apgas_pkg::VAL_BITS;
	localparam int DEPTH = (MAX_ENTRIES < (1 << apgas_pkg::IDX_BITS)) ? MAX_ENTRIES
	                       : (1 << apgas_pkg::IDX_BITS);
	localparam int AW    = $clog2(DEPTH);
	localparam int CAP   = (MAX_ENTRIES < (1 << apgas_pkg::CNT_BITS) - 1) ? MAX_ENTRIES
	                       : (1 << apgas_pkg::CNT_BITS) - 1;
	localparam int EB    = apgas_pkg::EPOCH_BITS;
	localparam int TB    = apgas_pkg::TOTAL_BITS;
	localparam int CB    = apgas_pkg::CNT_BITS;

	localparam logic [CB-1:0] CAP_C   = CB'(CAP);
	localparam logic [EB-1:0] EPOCH_1 = EB'(1);
	localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

	// entry memory: value and epoch tag
	logic [SW+EB-1:0] mem [DEPTH];
	logic [SW+EB-1:0] rd_q;

	apgas_pkg::item_t   item_q;
	logic [CB-1:0]      cnt_q;
	logic [SW-1:0]      bcast_q;
	logic [TB-1:0]      total_q;
	logic [EB-1:0]      epoch_q;
	logic [AW-1:0]      clr_q;
	apgas_pkg::result_t result_q;
	logic               done_q;

	logic [CB-1:0]      cnt_eff;
	logic [SW-1:0]      val;
	logic [AW-1:0]      addr;
	logic [SW+CB-1:0]   prod_full;
	logic [TB-1:0]      prod;
	logic [SW-1:0]      old_val;
	logic [TB-1:0]      total_pt;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [SW+EB-1:0]   mem_wd;

	// effective entry count and operands
	assign cnt_eff   = (cnt_q > CAP_C) ? CAP_C : cnt_q;
	assign val       = item_q.value[SW-1:0];
	assign addr      = item_q.index[AW-1:0];
	assign prod_full = cnt_eff * val;
	assign prod      = TB'(prod_full);

	// entry reads as broadcast value unless tagged with current epoch
	assign old_val  = (rd_q[EB-1:0] == epoch_q) ? rd_q[SW+EB-1:EB] : bcast_q;
	assign total_pt = total_q - TB'(old_val) + TB'(val);

	assign status.is_set_all = (item_q.action == apgas_pkg::ACT_ALL);
	assign status.bad        = ({1'b0, item_q.index} >= cnt_eff);
	assign status.epoch_wrap = &epoch_q;
	assign status.clr_last   = (clr_q == LAST_A);

	// memory write select: point set or clearing pass
	always_comb begin
		mem_we = cmd.point_upd | cmd.clr_en;
		mem_wa = cmd.clr_en ? clr_q : addr;
		mem_wd = cmd.clr_en ? '0 : {val, epoch_q};
	end

	// entry memory ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[addr];
		end
	end

	// captured item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	// entry count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= apgas_pkg::CNT_RESET;
		end else if (cfg_valid) begin
			cnt_q <= cfg_data;
		end
	end

	// total, broadcast value, epoch and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			bcast_q <= '0;
			epoch_q <= EPOCH_1;
			clr_q   <= '0;
		end else begin
			if (cmd.set_all) begin
				total_q <= prod;
				bcast_q <= val;
				epoch_q <= status.epoch_wrap ? EPOCH_1 : epoch_q + EPOCH_1;
			end else if (cmd.point_upd) begin
				total_q <= total_pt;
			end
			if (cmd.clr_en) begin
				clr_q <= status.clr_last ? '0 : clr_q + AW'(1);
			end
		end
	end

	// result word and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.set_all | cmd.point_upd | cmd.bad_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_all) begin
			result_q <= '{total: prod, bad_index: 1'b0};
		end else if (cmd.point_upd) begin
			result_q <= '{total: total_pt, bad_index: 1'b0};
		end else if (cmd.bad_emit) begin
			result_q <= '{total: total_q, bad_index: 1'b1};
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

FILE: sv/array_point_and_global_assign_sum.sv
// Table of unsigned entries with a running total. An item is taken when start is high
// and busy is low; action 0 writes one entry, action 1 gives every entry in use the
// same value. Each item yields one word on result, marked by done for exactly one
// cycle, which cannot be held off. A point set passes through capture, memory read and
// read-modify-write, a set-all or a rejected index through capture and execute only;
// done follows in the cycle after the last of them. The registered read of the entry
// memory is what adds the read step for a point set. Set-all is lazy: it bumps an epoch
// tag instead of touching the memory. After reset, and after every 255th set-all when
// the tag wraps, busy stays high for a clearing pass over min(MAX_ENTRIES, 1024)
// entries. The entry count register may be written at any time that no item is in
// flight; cfg_ready is always high.
module array_point_and_global_assign_sum #(
	parameter int MAX_ENTRIES = 1024,
	parameter int VALUE_BITS  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  apgas_pkg::item_t               item,
	output logic                           done,
	output apgas_pkg::result_t             result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [apgas_pkg::CNT_BITS-1:0] cfg_data
);

	apgas_pkg::cmd_t    cmd;
	apgas_pkg::status_t status;

	// config word always accepted
	assign cfg_ready = 1'b1;

	// controller
	apgas_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	// datapath
	apgas_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.VALUE_BITS  (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.result    (result),
		.done      (done)
	);

endmodule

FILE: tb/array_point_and_global_assign_sum_tb.sv
`timescale 1ns / 100ps

module array_point_and_global_assign_sum_tb;

	localparam int TABLE_DEPTH = 1024;
	localparam int RAND_PHASES = 14;
	localparam int PHASE_ITEMS = 125;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	apgas_pkg::item_t op_word = '0;
	logic done;
	apgas_pkg::result_t res_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [apgas_pkg::CNT_BITS-1:0] cfg_data = '0;

	// mirror of the table, the lazy fill value and the running total
	logic [apgas_pkg::VAL_BITS-1:0] table_val [TABLE_DEPTH];
	logic table_set [TABLE_DEPTH];
	logic [apgas_pkg::VAL_BITS-1:0] fill_value = '0;
	logic [apgas_pkg::TOTAL_BITS-1:0] run_sum = '0;
	logic [apgas_pkg::CNT_BITS-1:0] entry_count = apgas_pkg::CNT_RESET;

	apgas_pkg::item_t op_q [$];
	apgas_pkg::result_t total_q [$];

	// handshake flags sampled at the rising edge, read at the falling edge
	logic item_taken = 1'b0;
	logic cfg_taken = 1'b0;

	int gap_left = 0;
	int stretch_left = 40;
	logic steady = 1'b0;

	int cycle_count = 0;
	int mismatches = 0;
	int n_point = 0;
	int n_all = 0;
	int n_bad = 0;
	int n_checked = 0;
	int n_cfg = 0;

	array_point_and_global_assign_sum #(
		.MAX_ENTRIES(TABLE_DEPTH),
		.VALUE_BITS(apgas_pkg::VAL_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(op_word),
		.done(done),
		.result(res_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// apply one operation to the mirror and return the total it should report
	function automatic apgas_pkg::result_t apply_op(apgas_pkg::item_t it);
		apgas_pkg::result_t r;
		logic [63:0] prod;
		logic [apgas_pkg::VAL_BITS-1:0] prior;
		int eff;
		eff = (int'(entry_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
		r.bad_index = 1'b0;
		if (it.action == apgas_pkg::ACT_ALL) begin
			foreach (table_set[i]) table_set[i] = 1'b0;
			fill_value = it.value;
			prod = 64'(eff) * 64'(it.value);
			run_sum = prod[apgas_pkg::TOTAL_BITS-1:0];
		end else if (int'(it.index) >= eff) begin
			r.bad_index = 1'b1;
		end else begin
			prior = table_set[it.index] ? table_val[it.index] : fill_value;
			run_sum = run_sum - apgas_pkg::TOTAL_BITS'(prior)
				+ apgas_pkg::TOTAL_BITS'(it.value);
			table_val[it.index] = it.value;
			table_set[it.index] = 1'b1;
		end
		r.total = run_sum;
		return r;
	endfunction

	// mostly short gaps, a few long ones, none during a steady stretch
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(10, 40);
	endfunction

	// random operation: indexes cluster on a few hot entries so set-all gets undone often
	function automatic apgas_pkg::item_t rand_op(int eff, int all_pct);
		apgas_pkg::item_t it;
		int r;
		it.action = ($urandom_range(0, 99) < all_pct) ? apgas_pkg::ACT_ALL
			: apgas_pkg::ACT_POINT;
		r = $urandom_range(0, 99);
		if (eff == 0 || (r < 10 && eff >= TABLE_DEPTH))
			it.index = apgas_pkg::IDX_BITS'($urandom);
		else if (r < 10)
			it.index = apgas_pkg::IDX_BITS'($urandom_range(TABLE_DEPTH - 1, eff));
		else if (r < 55)
			it.index = apgas_pkg::IDX_BITS'($urandom_range(((eff < 8) ? eff : 8) - 1, 0));
		else
			it.index = apgas_pkg::IDX_BITS'($urandom_range(eff - 1, 0));
		r = $urandom_range(0, 99);
		if (r < 15)
			it.value = '0;
		else if (r < 30)
			it.value = '1;
		else
			it.value = apgas_pkg::VAL_BITS'($urandom);
		return it;
	endfunction

	task automatic push_op(logic act, int idx, logic [apgas_pkg::VAL_BITS-1:0] val);
		apgas_pkg::item_t it;
		it.action = act;
		it.index = apgas_pkg::IDX_BITS'(idx);
		it.value = val;
		op_q.push_back(it);
	endtask

	// wait until every queued word has been taken and answered
	task automatic wait_idle();
		while (op_q.size() != 0 || start || total_q.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_count(logic [apgas_pkg::CNT_BITS-1:0] n);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	// driver: present the next word, holding start until it is taken
	always @(negedge clk) begin
		logic next_start;
		apgas_pkg::item_t next_word;
		next_start = start;
		next_word = op_word;
		if (start && item_taken) begin
			next_start = 1'b0;
			stretch_left--;
			if (stretch_left <= 0) begin
				steady = !steady;
				stretch_left = $urandom_range(20, 150);
			end
			gap_left = pick_gap();
		end
		if (!next_start) begin
			if (gap_left > 0)
				gap_left--;
			else if (op_q.size() != 0) begin
				next_start = 1'b1;
				next_word = op_q.pop_front();
			end
		end
		start <= next_start;
		op_word <= next_word;
	end

	// monitor: predict on every accepted word, check every done strobe
	always @(posedge clk) begin
		apgas_pkg::result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d totals outstanding", cycle_count,
				total_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
		item_taken = arst_n && start && !busy;
		cfg_taken = arst_n && cfg_valid && cfg_ready;
		if (cfg_taken) begin
			entry_count = cfg_data;
			n_cfg++;
		end
		if (item_taken) begin
			total_q.push_back(apply_op(op_word));
			if (op_word.action == apgas_pkg::ACT_ALL)
				n_all++;
			else
				n_point++;
		end
		if (arst_n && done) begin
			if (total_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result total=%0d bad_index=%0b", $time,
					res_word.total, res_word.bad_index);
			end else begin
				want = total_q.pop_front();
				n_checked++;
				if (want.bad_index)
					n_bad++;
				if (res_word.total !== want.total) begin
					mismatches++;
					$display("%0t: total expected %0d actual %0d", $time, want.total,
						res_word.total);
				end
				if (res_word.bad_index !== want.bad_index) begin
					mismatches++;
					$display("%0t: bad_index expected %0b actual %0b", $time,
						want.bad_index, res_word.bad_index);
				end
			end
		end
	end

	// stimulus
	initial begin
		int eff;
		int all_pct;
		logic [apgas_pkg::CNT_BITS-1:0] cnt;
		foreach (table_set[i]) begin
			table_set[i] = 1'b0;
			table_val[i] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// full table at reset count: extremes, overwrite, set-all then rewrite
		push_op(apgas_pkg::ACT_POINT, 0, '1);
		push_op(apgas_pkg::ACT_POINT, TABLE_DEPTH - 1, '1);
		push_op(apgas_pkg::ACT_POINT, 0, '0);
		push_op(apgas_pkg::ACT_ALL, TABLE_DEPTH - 1, '1);
		push_op(apgas_pkg::ACT_POINT, 5, '0);
		push_op(apgas_pkg::ACT_POINT, 5, 32'h1234_5678);
		push_op(apgas_pkg::ACT_POINT, 'h2AA, 32'h5555_5555);
		push_op(apgas_pkg::ACT_POINT, 'h155, 32'hAAAA_AAAA);
		push_op(apgas_pkg::ACT_ALL, 0, '0);

		// single entry: rejected indexes
		write_count(11'd1);
		push_op(apgas_pkg::ACT_ALL, 0, '1);
		push_op(apgas_pkg::ACT_POINT, 0, 32'd5);
		push_op(apgas_pkg::ACT_POINT, 1, 32'd7);
		push_op(apgas_pkg::ACT_POINT, TABLE_DEPTH - 1, 32'd9);

		// count raised without recompute: total wraps below zero and back
		write_count(11'd1024);
		push_op(apgas_pkg::ACT_POINT, 3, '0);
		push_op(apgas_pkg::ACT_POINT, 4, '1);
		push_op(apgas_pkg::ACT_POINT, 0, '1);

		// zero count: every point set rejected, set-all gives zero
		write_count(11'd0);
		push_op(apgas_pkg::ACT_POINT, 0, 32'd1);
		push_op(apgas_pkg::ACT_ALL, 7, '1);

		// count above the table size is capped
		write_count(11'd2047);
		push_op(apgas_pkg::ACT_ALL, 0, 32'd1);
		push_op(apgas_pkg::ACT_POINT, TABLE_DEPTH - 1, '0);
		push_op(apgas_pkg::ACT_POINT, 0, '1);

		// random phases with changing count and set-all density
		for (int p = 0; p < RAND_PHASES; p++) begin
			case ($urandom_range(0, 7))
				0: cnt = 11'd1024;
				1: cnt = 11'd2047;
				2: cnt = 11'd1;
				3: cnt = 11'd2;
				4: cnt = apgas_pkg::CNT_BITS'($urandom_range(1, 1024));
				5: cnt = apgas_pkg::CNT_BITS'($urandom_range(3, 16));
				6: cnt = apgas_pkg::CNT_BITS'($urandom_range(0, 2047));
				default: cnt = 11'd1025;
			endcase
			if (p == 0)
				cnt = 11'd1024;
			write_count(cnt);
			eff = (int'(cnt) > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt);
			case ($urandom_range(0, 3))
				0: all_pct = 5;
				1: all_pct = 25;
				2: all_pct = 45;
				default: all_pct = 85;
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++)
				op_q.push_back(rand_op(eff, all_pct));
		end

		// drain and let any stray result show up
		wait_idle();
		repeat (10) @(negedge clk);
		if (total_q.size() != 0) begin
			mismatches++;
			$display("%0t: %0d expected totals never arrived", $time, total_q.size());
		end
		$display("covered %0d point sets (%0d rejected) and %0d set-alls over %0d count writes",
			n_point, n_bad, n_all, n_cfg);
		$display("%0d totals compared, %0d mismatches", n_checked, mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
